// ----- design/tbdc_pkg.sv -----
package tbdc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF  = 8;
    localparam int TIMER_BITS_DEF  = 16;

    localparam int HOLD_BITS  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int THRESHOLD_RESET = 180;
    localparam int WINDOW_RESET    = 1000;
    localparam int HOLDOFF_RESET   = 150;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_HOLDOFF   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        FN_SAMPLE = 3'd0,
        FN_TICK   = 3'd1,
        FN_LOAD   = 3'd2,
        FN_ADD    = 3'd3,
        FN_REMOVE = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        PAT_OTHER     = 3'd0,
        PAT_ROOM_ONLY = 3'd1,
        PAT_CORR_ONLY = 3'd2,
        PAT_BOTH      = 3'd3,
        PAT_QUIET     = 3'd4
    } pattern_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_ROOM_FIRST = 3'd1,
        PH_ROOM_BOTH  = 3'd2,
        PH_CORR_FIRST = 3'd3,
        PH_CORR_BOTH  = 3'd4,
        PH_HOLD       = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CR_NONE  = 2'd0,
        CR_ENTRY = 2'd1,
        CR_EXIT  = 2'd2
    } crossing_t;

    // Classified item handed from the front to the engine.
    typedef struct packed {
        func_t    func;
        pattern_t pattern;
    } item_t;

endpackage

// ----- design/two_beam_direction_counter_core.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  func, room_level, corridor_level, count_value
// m_        out        m_valid / m_ready  people_count, occupied, crossing, phase
// apb       in         psel/penable/...   threshold, window_ticks, holdoff_ticks
//
// One transaction per cycle sustained while m_ready is high; each produces exactly one result.
// The front classifies each transaction into a two-entry queue, then the engine
// updates state and loads the output register.
// s_ready falls only when the queue holds two transactions (m_ready held low).
// aresetn is synchronous; it restores the default registers and idle state.
module two_beam_direction_counter_core import tbdc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_func,
    input  logic [SAMPLE_BITS-1:0] s_room_level,
    input  logic [SAMPLE_BITS-1:0] s_corridor_level,
    input  logic [COUNT_BITS-1:0]  s_count_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_BITS-1:0]  m_people_count,
    output logic                   m_occupied,
    output logic [1:0]             m_crossing,
    output logic [2:0]             m_phase
);

    localparam int Q_WIDTH = $bits(item_t) + COUNT_BITS;

    item_t                 front_item, head_item;
    logic [TIMER_BITS-1:0] window_ticks;
    logic [HOLD_BITS-1:0]  holdoff_ticks;
    logic                  q_push, q_pop, q_not_full, q_not_empty;
    logic [Q_WIDTH-1:0]    q_head;
    logic [COUNT_BITS-1:0] head_count;

    tbdc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_func           (s_func),
        .s_room_level     (s_room_level),
        .s_corridor_level (s_corridor_level),
        .item             (front_item),
        .window_ticks     (window_ticks),
        .holdoff_ticks    (holdoff_ticks)
    );

    assign s_ready = q_not_full;
    assign q_push  = s_valid && q_not_full;

    tbdc_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({front_item, s_count_value}),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    assign head_item  = item_t'(q_head[Q_WIDTH-1:COUNT_BITS]);
    assign head_count = q_head[COUNT_BITS-1:0];

    tbdc_engine #(
        .COUNT_BITS (COUNT_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_item         (head_item),
        .q_count_value  (head_count),
        .q_pop          (q_pop),
        .window_ticks   (window_ticks),
        .holdoff_ticks  (holdoff_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_people_count (m_people_count),
        .m_occupied     (m_occupied),
        .m_crossing     (m_crossing),
        .m_phase        (m_phase)
    );

endmodule

// ----- design/tbdc_front.sv -----
module tbdc_front import tbdc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic [2:0]             s_func,
    input  logic [SAMPLE_BITS-1:0] s_room_level,
    input  logic [SAMPLE_BITS-1:0] s_corridor_level,
    output item_t                  item,
    output logic [TIMER_BITS-1:0]  window_ticks,
    output logic [HOLD_BITS-1:0]   holdoff_ticks
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    // Clamp the window reset into a narrow timer: a window at the timer's
    // maximum never expires, same as one beyond it.
    localparam logic [TIMER_BITS-1:0] WINDOW_INIT =
        (longint'(WINDOW_RESET) > longint'(TIMER_MAX)) ? TIMER_MAX
                                                      : TIMER_BITS'(WINDOW_RESET);

    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [TIMER_BITS-1:0]  window_reg;
    logic [HOLD_BITS-1:0]   holdoff_reg;
    reg_index_t             reg_sel;
    logic                   wr_en;
    logic                   room_hi, corr_hi, room_lo, corr_lo;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= SAMPLE_BITS'(THRESHOLD_RESET);
            window_reg    <= WINDOW_INIT;
            holdoff_reg   <= HOLD_BITS'(HOLDOFF_RESET);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_THRESHOLD: threshold_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_WINDOW:    window_reg    <= pwdata[TIMER_BITS-1:0];
                REG_HOLDOFF:   holdoff_reg   <= pwdata[HOLD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_WINDOW:    prdata = APB_DATA_W'(window_reg);
            REG_HOLDOFF:   prdata = APB_DATA_W'(holdoff_reg);
            default:       prdata = '0;
        endcase
    end

    assign window_ticks  = window_reg;
    assign holdoff_ticks = holdoff_reg;

    // Beam patterns; a level equal to the threshold is neither blocked nor clear.
    assign room_hi = s_room_level > threshold_reg;
    assign corr_hi = s_corridor_level > threshold_reg;
    assign room_lo = s_room_level < threshold_reg;
    assign corr_lo = s_corridor_level < threshold_reg;

    always_comb begin
        item.func = func_t'(s_func);
        if (room_hi && corr_lo) begin
            item.pattern = PAT_ROOM_ONLY;
        end else if (corr_hi && room_lo) begin
            item.pattern = PAT_CORR_ONLY;
        end else if (room_hi && corr_hi) begin
            item.pattern = PAT_BOTH;
        end else if (!room_hi && !corr_hi) begin
            item.pattern = PAT_QUIET;
        end else begin
            item.pattern = PAT_OTHER;
        end
    end

endmodule

// ----- design/tbdc_queue.sv -----
module tbdc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign not_full  = count_reg != 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/tbdc_engine.sv -----
module tbdc_engine import tbdc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  item_t                 q_item,
    input  logic [COUNT_BITS-1:0] q_count_value,
    output logic                  q_pop,
    input  logic [TIMER_BITS-1:0] window_ticks,
    input  logic [HOLD_BITS-1:0]  holdoff_ticks,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_people_count,
    output logic                  m_occupied,
    output logic [1:0]            m_crossing,
    output logic [2:0]            m_phase
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [HOLD_BITS-1:0]  HOLD_MAX  = {HOLD_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] window_reg, window_next, window_inc;
    logic [HOLD_BITS-1:0]  hold_reg, hold_next, hold_inc;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_inc, count_dec;
    logic                  occ_reg, occ_next;
    crossing_t             crossing_next;

    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0] m_count_reg;
    logic                  m_occ_reg;
    crossing_t             m_crossing_reg;
    phase_t                m_phase_reg;

    // Take the next transaction whenever the output slot is free or draining.
    assign q_pop        = q_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = q_pop || (m_valid_reg && !m_ready);

    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_dec  = (count_reg == '0) ? count_reg : count_reg - 1'b1;
    assign window_inc = (window_reg == TIMER_MAX) ? window_reg : window_reg + 1'b1;
    assign hold_inc   = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;

    always_comb begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        hold_next     = hold_reg;
        count_next    = count_reg;
        occ_next      = occ_reg;
        crossing_next = CR_NONE;
        unique case (q_item.func)
            FN_SAMPLE: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (q_item.pattern == PAT_ROOM_ONLY) begin
                            phase_next  = PH_ROOM_FIRST;
                            window_next = '0;
                        end else if (q_item.pattern == PAT_CORR_ONLY) begin
                            phase_next  = PH_CORR_FIRST;
                            window_next = '0;
                        end
                    end
                    PH_ROOM_FIRST: begin
                        if (q_item.pattern == PAT_BOTH) begin
                            phase_next = PH_ROOM_BOTH;
                        end
                    end
                    PH_CORR_FIRST: begin
                        if (q_item.pattern == PAT_BOTH) begin
                            phase_next = PH_CORR_BOTH;
                        end
                    end
                    PH_ROOM_BOTH: begin
                        if (q_item.pattern == PAT_CORR_ONLY) begin
                            count_next    = count_dec;
                            occ_next      = (count_dec == '0) ? 1'b0 : occ_reg;
                            crossing_next = CR_EXIT;
                            hold_next     = '0;
                            phase_next    = PH_HOLD;
                        end else if (q_item.pattern == PAT_QUIET) begin
                            // Fall back without restarting the window.
                            phase_next = PH_ROOM_FIRST;
                        end
                    end
                    PH_CORR_BOTH: begin
                        if (q_item.pattern == PAT_ROOM_ONLY) begin
                            count_next    = count_inc;
                            occ_next      = 1'b1;
                            crossing_next = CR_ENTRY;
                            hold_next     = '0;
                            phase_next    = PH_HOLD;
                        end else if (q_item.pattern == PAT_QUIET) begin
                            phase_next = PH_CORR_FIRST;
                        end
                    end
                    default: ;
                endcase
            end
            FN_TICK: begin
                unique case (phase_reg)
                    PH_ROOM_FIRST, PH_CORR_FIRST: begin
                        window_next = window_inc;
                        if (window_inc > window_ticks) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ROOM_BOTH, PH_CORR_BOTH: begin
                        window_next = window_inc;
                    end
                    PH_HOLD: begin
                        hold_next = hold_inc;
                        if (hold_inc >= holdoff_ticks) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            FN_LOAD: begin
                count_next = q_count_value;
            end
            FN_ADD: begin
                count_next = count_inc;
                occ_next   = 1'b1;
            end
            FN_REMOVE: begin
                count_next = count_dec;
                occ_next   = (count_dec == '0) ? 1'b0 : occ_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            window_reg  <= '0;
            hold_reg    <= '0;
            count_reg   <= '0;
            occ_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                phase_reg  <= phase_next;
                window_reg <= window_next;
                hold_reg   <= hold_next;
                count_reg  <= count_next;
                occ_reg    <= occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_count_reg    <= count_next;
            m_occ_reg      <= occ_next;
            m_crossing_reg <= crossing_next;
            m_phase_reg    <= phase_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_people_count = m_count_reg;
    assign m_occupied     = m_occ_reg;
    assign m_crossing     = m_crossing_reg;
    assign m_phase        = m_phase_reg;

endmodule

// ----- design/tbdc_checker.sv -----
module tbdc_checker import tbdc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COUNT_BITS-1:0] m_people_count,
    input logic                  m_occupied,
    input logic [1:0]            m_crossing,
    input logic [2:0]            m_phase
);

    // An entry always leaves the room occupied and starts the hold-off.
    a_entry_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_crossing == CR_ENTRY) |-> (m_occupied && m_phase == PH_HOLD))
        else $error("entry result without occupied hold-off");

    // An exit is always followed by the hold-off phase.
    a_exit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_crossing == CR_EXIT) |-> (m_phase == PH_HOLD))
        else $error("exit result outside hold-off");

    // Nothing is offered on the result side in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_people_count) && $stable(m_phase)
             && $stable(m_crossing) && $stable(m_occupied)))
        else $error("stalled result changed");

endmodule

bind two_beam_direction_counter_core tbdc_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_tbdc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_people_count (m_people_count),
    .m_occupied     (m_occupied),
    .m_crossing     (m_crossing),
    .m_phase        (m_phase)
);

// ----- tb/people_count_checker.sv -----
module people_count_checker
    import tbdc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    input  logic [APB_DATA_W-1:0]      prdata,
    input  logic                       pready,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [2:0]                 s_func,
    input  logic [SAMPLE_BITS_DEF-1:0] s_room_level,
    input  logic [SAMPLE_BITS_DEF-1:0] s_corridor_level,
    input  logic [COUNT_BITS_DEF-1:0]  s_count_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [COUNT_BITS_DEF-1:0]  m_people_count,
    input  logic                       m_occupied,
    input  logic [1:0]                 m_crossing,
    input  logic [2:0]                 m_phase,
    output int                         pending,
    output int                         mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [COUNT_BITS_DEF-1:0] people;
        logic                      occupied;
        crossing_t                 crossing;
        phase_t                    phase;
    } count_result_t;

    count_result_t expected_counts[$];

    logic [SAMPLE_BITS_DEF-1:0] threshold_cfg;
    logic [TIMER_BITS_DEF-1:0]  window_cfg;
    logic [HOLD_BITS-1:0]       holdoff_cfg;

    phase_t                     phase_q;
    logic [TIMER_BITS_DEF-1:0]  window_cnt;
    logic [HOLD_BITS-1:0]       holdoff_cnt;
    logic [COUNT_BITS_DEF-1:0]  people_q;
    logic                       occupied_q;

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [APB_DATA_W-1:0] register_value(logic [APB_ADDR_W-1:0] addr);
        case (reg_index_t'(addr[3:2]))
            REG_THRESHOLD: return APB_DATA_W'(threshold_cfg);
            REG_WINDOW:    return APB_DATA_W'(window_cfg);
            REG_HOLDOFF:   return APB_DATA_W'(holdoff_cfg);
            default:       return '0;
        endcase
    endfunction

    function automatic void count_entry();
        if (people_q != '1)
            people_q = people_q + 1'b1;
        occupied_q = 1'b1;
    endfunction

    function automatic void count_exit();
        if (people_q != '0)
            people_q = people_q - 1'b1;
        if (people_q == '0)
            occupied_q = 1'b0;
    endfunction

    function automatic count_result_t predict_count(logic [2:0] fn,
                                                    logic [SAMPLE_BITS_DEF-1:0] room,
                                                    logic [SAMPLE_BITS_DEF-1:0] corr,
                                                    logic [COUNT_BITS_DEF-1:0] value);
        count_result_t res;
        pattern_t      pat;
        crossing_t     cr;
        logic          room_hi;
        logic          corr_hi;
        cr = CR_NONE;
        case (fn)
            FN_SAMPLE: begin
                room_hi = room > threshold_cfg;
                corr_hi = corr > threshold_cfg;
                // single-beam patterns need the other beam strictly below threshold
                if (room_hi && corr < threshold_cfg)
                    pat = PAT_ROOM_ONLY;
                else if (corr_hi && room < threshold_cfg)
                    pat = PAT_CORR_ONLY;
                else if (room_hi && corr_hi)
                    pat = PAT_BOTH;
                else if (!room_hi && !corr_hi)
                    pat = PAT_QUIET;
                else
                    pat = PAT_OTHER;
                case (phase_q)
                    PH_IDLE: begin
                        if (pat == PAT_ROOM_ONLY) begin
                            phase_q = PH_ROOM_FIRST;
                            window_cnt = '0;
                        end else if (pat == PAT_CORR_ONLY) begin
                            phase_q = PH_CORR_FIRST;
                            window_cnt = '0;
                        end
                    end
                    PH_ROOM_FIRST: begin
                        if (pat == PAT_BOTH)
                            phase_q = PH_ROOM_BOTH;
                    end
                    PH_CORR_FIRST: begin
                        if (pat == PAT_BOTH)
                            phase_q = PH_CORR_BOTH;
                    end
                    PH_ROOM_BOTH: begin
                        if (pat == PAT_CORR_ONLY) begin
                            count_exit();
                            cr = CR_EXIT;
                            holdoff_cnt = '0;
                            phase_q = PH_HOLD;
                        end else if (pat == PAT_QUIET) begin
                            // window keeps running
                            phase_q = PH_ROOM_FIRST;
                        end
                    end
                    PH_CORR_BOTH: begin
                        if (pat == PAT_ROOM_ONLY) begin
                            count_entry();
                            cr = CR_ENTRY;
                            holdoff_cnt = '0;
                            phase_q = PH_HOLD;
                        end else if (pat == PAT_QUIET) begin
                            phase_q = PH_CORR_FIRST;
                        end
                    end
                    default: ;
                endcase
            end
            FN_TICK: begin
                case (phase_q)
                    PH_ROOM_FIRST, PH_CORR_FIRST, PH_ROOM_BOTH, PH_CORR_BOTH: begin
                        if (window_cnt != '1)
                            window_cnt = window_cnt + 1'b1;
                        if ((phase_q == PH_ROOM_FIRST || phase_q == PH_CORR_FIRST) &&
                            window_cnt > window_cfg)
                            phase_q = PH_IDLE;
                    end
                    PH_HOLD: begin
                        if (holdoff_cnt != '1)
                            holdoff_cnt = holdoff_cnt + 1'b1;
                        if (holdoff_cnt >= holdoff_cfg)
                            phase_q = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            FN_LOAD:   people_q = value;
            FN_ADD:    count_entry();
            FN_REMOVE: count_exit();
            default: ;
        endcase
        res.people   = people_q;
        res.occupied = occupied_q;
        res.crossing = cr;
        res.phase    = phase_q;
        return res;
    endfunction

    always @(posedge aclk) begin
        count_result_t want;
        if (!aresetn) begin
            threshold_cfg = SAMPLE_BITS_DEF'(THRESHOLD_RESET);
            window_cfg    = TIMER_BITS_DEF'(WINDOW_RESET);
            holdoff_cfg   = HOLD_BITS'(HOLDOFF_RESET);
            phase_q       = PH_IDLE;
            window_cnt    = '0;
            holdoff_cnt   = '0;
            people_q      = '0;
            occupied_q    = 1'b0;
            mismatches    = 0;
            expected_counts.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_index_t'(paddr[3:2]))
                        REG_THRESHOLD: threshold_cfg = pwdata[SAMPLE_BITS_DEF-1:0];
                        REG_WINDOW:    window_cfg    = pwdata[TIMER_BITS_DEF-1:0];
                        REG_HOLDOFF:   holdoff_cfg   = pwdata[HOLD_BITS-1:0];
                        default: ;
                    endcase
                end else if (prdata !== register_value(paddr)) begin
                    report_mismatch($sformatf("read of address %0d returned %0d, expected %0d",
                                              paddr, prdata, register_value(paddr)));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result transaction with nothing pending (count %0d)",
                                              m_people_count));
                end else begin
                    want = expected_counts.pop_front();
                    if (m_people_count !== want.people)
                        report_mismatch($sformatf("people_count %0d, expected %0d",
                                                  m_people_count, want.people));
                    if (m_occupied !== want.occupied)
                        report_mismatch($sformatf("occupied %0d, expected %0d",
                                                  m_occupied, want.occupied));
                    if (m_crossing !== want.crossing)
                        report_mismatch($sformatf("crossing %0d, expected %0d",
                                                  m_crossing, want.crossing));
                    if (m_phase !== want.phase)
                        report_mismatch($sformatf("phase %0d, expected %0d",
                                                  m_phase, want.phase));
                end
            end
            if (s_valid && s_ready)
                expected_counts.push_back(predict_count(s_func, s_room_level,
                                                        s_corridor_level, s_count_value));
        end
        pending <= expected_counts.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tbdc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SEGMENT_ITEMS = 100;
    localparam int SEGMENTS      = 9;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic [2:0]                 s_func;
    logic [SAMPLE_BITS_DEF-1:0] s_room_level;
    logic [SAMPLE_BITS_DEF-1:0] s_corridor_level;
    logic [COUNT_BITS_DEF-1:0]  s_count_value;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [COUNT_BITS_DEF-1:0]  m_people_count;
    logic                       m_occupied;
    logic [1:0]                 m_crossing;
    logic [2:0]                 m_phase;

    int pending;
    int mismatches;
    int cycle_count = 0;
    int items_sent  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    logic [SAMPLE_BITS_DEF-1:0] cur_threshold;
    logic [TIMER_BITS_DEF-1:0]  cur_window;
    logic [HOLD_BITS-1:0]       cur_holdoff;

    two_beam_direction_counter_core DUT (.*);

    people_count_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= (rx_idle_pct == 0) || ($urandom_range(99, 0) >= rx_idle_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_access(logic write, reg_index_t idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_registers();
        apb_access(1'b0, REG_THRESHOLD, '0);
        apb_access(1'b0, REG_WINDOW, '0);
        apb_access(1'b0, REG_HOLDOFF, '0);
    endtask

    task automatic configure(logic [SAMPLE_BITS_DEF-1:0] thr, logic [TIMER_BITS_DEF-1:0] win,
                             logic [HOLD_BITS-1:0] hold);
        apb_access(1'b1, REG_THRESHOLD, APB_DATA_W'(thr));
        apb_access(1'b1, REG_WINDOW, APB_DATA_W'(win));
        apb_access(1'b1, REG_HOLDOFF, APB_DATA_W'(hold));
        cur_threshold = thr;
        cur_window    = win;
        cur_holdoff   = hold;
        read_registers();
    endtask

    // hold the channel quiet until every pending result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(logic [2:0] fn, logic [SAMPLE_BITS_DEF-1:0] room,
                             logic [SAMPLE_BITS_DEF-1:0] corr, logic [COUNT_BITS_DEF-1:0] value);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= fn;
        s_room_level     <= room;
        s_corridor_level <= corr;
        s_count_value    <= value;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_item(FN_TICK, SAMPLE_BITS_DEF'($urandom), SAMPLE_BITS_DEF'($urandom),
                      COUNT_BITS_DEF'($urandom));
    endtask

    task automatic send_noise();
        send_item(3'($urandom_range(7, 0)), SAMPLE_BITS_DEF'($urandom),
                  SAMPLE_BITS_DEF'($urandom), COUNT_BITS_DEF'($urandom));
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] blocked_level();
        if (cur_threshold == '1)
            return '1;
        return SAMPLE_BITS_DEF'($urandom_range((1 << SAMPLE_BITS_DEF) - 1, int'(cur_threshold) + 1));
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] clear_level();
        if (cur_threshold == '0)
            return '0;
        return SAMPLE_BITS_DEF'($urandom_range(int'(cur_threshold) - 1, 0));
    endfunction

    task automatic send_pattern(pattern_t pat);
        logic [SAMPLE_BITS_DEF-1:0] room;
        logic [SAMPLE_BITS_DEF-1:0] corr;
        case (pat)
            PAT_ROOM_ONLY: begin
                room = blocked_level();
                corr = clear_level();
            end
            PAT_CORR_ONLY: begin
                room = clear_level();
                corr = blocked_level();
            end
            PAT_BOTH: begin
                room = blocked_level();
                corr = blocked_level();
            end
            PAT_QUIET: begin
                room = SAMPLE_BITS_DEF'($urandom_range(int'(cur_threshold), 0));
                corr = SAMPLE_BITS_DEF'($urandom_range(int'(cur_threshold), 0));
            end
            default: begin
                // one beam blocked, the other sitting exactly on the threshold
                room = blocked_level();
                corr = cur_threshold;
                if ($urandom_range(1, 0) == 1) begin
                    corr = room;
                    room = cur_threshold;
                end
            end
        endcase
        send_item(FN_SAMPLE, room, corr, COUNT_BITS_DEF'($urandom));
    endtask

    task automatic walk_through(logic inward);
        pattern_t first_pat;
        pattern_t last_pat;
        first_pat = inward ? PAT_CORR_ONLY : PAT_ROOM_ONLY;
        last_pat  = inward ? PAT_ROOM_ONLY : PAT_CORR_ONLY;
        send_pattern(first_pat);
        send_ticks($urandom_range(2, 0));
        if ($urandom_range(9, 0) == 0)
            send_pattern(PAT_OTHER);
        send_pattern(PAT_BOTH);
        if ($urandom_range(3, 0) == 0) begin
            send_pattern(PAT_QUIET);
            send_ticks($urandom_range(2, 0));
            send_pattern(PAT_BOTH);
        end
        send_pattern(last_pat);
        if ($urandom_range(3, 0) == 0)
            send_pattern(pattern_t'($urandom_range(4, 0)));
        if (cur_holdoff < 24)
            send_ticks(int'(cur_holdoff) + $urandom_range(1, 0));
        else
            send_ticks($urandom_range(4, 0));
    endtask

    initial begin
        int seg_start;
        int pick;
        aresetn          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        s_valid          <= 1'b0;
        s_func           <= FN_SAMPLE;
        s_room_level     <= '0;
        s_corridor_level <= '0;
        s_count_value    <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_registers();

        tx_idle_pct = 27;
        rx_idle_pct = 71;
        configure(180, 1, 2);

        send_item(FN_LOAD, '0, '0, '1);
        send_item(FN_ADD, '0, '0, '0);
        send_item(FN_SAMPLE, '0, '1, '0);
        send_item(FN_SAMPLE, '1, '1, '0);
        send_item(FN_SAMPLE, '0, '0, '0);
        send_item(FN_SAMPLE, 181, 181, '0);
        send_item(FN_SAMPLE, 181, 180, '0);
        send_item(FN_SAMPLE, '1, 179, '0);
        send_item(FN_SAMPLE, '0, '1, '0);
        send_ticks(3);
        send_item(FN_LOAD, '1, '1, '0);
        send_item(FN_SAMPLE, '1, '0, '0);
        send_ticks(1);
        send_item(FN_SAMPLE, '1, '1, '0);
        send_ticks(1);
        send_item(FN_SAMPLE, 180, 180, '0);
        send_ticks(1);
        send_item(FN_SAMPLE, 181, 180, '0);
        send_item(FN_SAMPLE, '1, '0, '0);
        send_item(FN_SAMPLE, '1, '1, '0);
        send_item(FN_SAMPLE, '0, '1, '0);
        send_item(FN_REMOVE, '0, '0, '0);
        for (int code = int'(FN_REMOVE) + 1; code < (1 << $bits(s_func)); code++)
            send_item(3'(code), SAMPLE_BITS_DEF'($urandom), SAMPLE_BITS_DEF'($urandom),
                      COUNT_BITS_DEF'($urandom));

        for (int k = 0; k < SEGMENTS; k++) begin
            tx_idle_pct = (k < 3) ? 27 : (k < 6) ? 71 : 0;
            rx_idle_pct = (k < 3) ? 71 : (k < 6) ? 27 : 0;
            drain_results();
            case (k)
                0: configure(180, 3, 0);
                1: configure(0, '1, 4);
                2: configure(517, 1, '1);
                3: configure('1, 12, 1);
                5: configure(1, '1, 0);
                6: configure(1022, 2, 40);
                default: configure(SAMPLE_BITS_DEF'($urandom_range((1 << SAMPLE_BITS_DEF) - 1, 0)),
                                   TIMER_BITS_DEF'($urandom_range(20, 1)),
                                   HOLD_BITS'($urandom_range(8, 0)));
            endcase
            seg_start = items_sent;
            if (cur_holdoff >= 24) begin
                // walk one crossing through the whole hold-off
                walk_through(1'b1);
                send_ticks(int'(cur_holdoff) + 1);
            end
            while (items_sent - seg_start < SEGMENT_ITEMS) begin
                pick = $urandom_range(19, 0);
                if (pick < 14)
                    walk_through(1'($urandom));
                else if (pick < 19)
                    send_noise();
                else
                    drain_results();
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
